@@ design/lkvc_pkg.sv @@
// shared types and constants of the lru key-value cache
package lkvc_pkg;

    // default number of entries
    localparam int unsigned CAPACITY_DEF = 16;

    // field widths
    localparam int unsigned CAP_W = 5;
    localparam int unsigned KEY_W = 32;
    localparam int unsigned VAL_W = 32;

    // capacity register value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // request kinds carried on tuser
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    // value returned by a get that misses
    localparam logic [VAL_W-1:0] READ_MISS = {VAL_W{1'b1}};

    // lookup outcome handed from the tag array to the top level
    typedef struct packed {
        logic hit;
        logic insert;
    } lkvc_lookup_t;

endpackage

@@ design/lkvc_tag_array.sv @@
// key store, valid bits, recency ranks and replacement logic
module lkvc_tag_array #(
    parameter int unsigned CAPACITY = lkvc_pkg::CAPACITY_DEF,
    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           upd_en,
    input  logic                           action,
    input  logic [lkvc_pkg::KEY_W-1:0]     key,
    input  logic [lkvc_pkg::CAP_W-1:0]     cap,
    output lkvc_pkg::lkvc_lookup_t         lookup,
    output logic [IW-1:0]                  hit_idx,
    output logic [IW-1:0]                  slot_idx
);

    localparam int unsigned OW = $clog2(CAPACITY + 1);
    localparam int unsigned EW = (OW > lkvc_pkg::CAP_W) ? OW : lkvc_pkg::CAP_W;

    logic [lkvc_pkg::KEY_W-1:0] key_reg   [CAPACITY];
    logic [IW-1:0]              rank_reg  [CAPACITY];
    logic [IW-1:0]              rank_next [CAPACITY];
    logic [CAPACITY-1:0]        valid_reg;
    logic [CAPACITY-1:0]        valid_next;
    logic [OW-1:0]              occ_reg;
    logic [OW-1:0]              occ_next;

    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] keep;
    logic [EW-1:0]       cap_lo;
    logic [EW-1:0]       eff_cap;
    logic [EW-1:0]       occ_kept;
    logic [IW-1:0]       hit_rank;
    logic                hit;

    // effective capacity, clamped to 1..CAPACITY
    always_comb
    begin
        cap_lo  = (cap == '0) ? EW'(1) : EW'(cap);
        eff_cap = (cap_lo > EW'(CAPACITY)) ? EW'(CAPACITY) : cap_lo;
    end

    // parallel key compare and survivor marks for an insert
    always_comb
    begin
        for (int j = 0; j < CAPACITY; j++)
        begin
            match[j] = valid_reg[j] && (key_reg[j] == key);
            keep[j]  = valid_reg[j] && ((EW'(rank_reg[j]) + EW'(1)) < eff_cap);
        end
    end

    // lowest matching entry and lowest free entry after eviction
    always_comb
    begin
        hit_idx  = '0;
        slot_idx = '0;
        for (int j = CAPACITY - 1; j >= 0; j--)
        begin
            if (match[j])
            begin
                hit_idx = IW'(j);
            end
            if (!keep[j])
            begin
                slot_idx = IW'(j);
            end
        end
    end

    assign hit           = |match;
    assign hit_rank      = rank_reg[hit_idx];
    assign occ_kept      = (EW'(occ_reg) >= eff_cap) ? (eff_cap - EW'(1)) : EW'(occ_reg);
    assign lookup.hit    = hit;
    assign lookup.insert = (action == lkvc_pkg::ACT_PUT) && !hit;

    // rank, valid and occupancy update
    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        occ_next   = occ_reg;
        if (upd_en)
        begin
            if (hit)
            begin
                // move the hit entry to the front
                for (int j = 0; j < CAPACITY; j++)
                begin
                    if (valid_reg[j] && (rank_reg[j] < hit_rank))
                    begin
                        rank_next[j] = rank_reg[j] + IW'(1);
                    end
                end
                rank_next[hit_idx] = '0;
            end
            else if (action == lkvc_pkg::ACT_PUT)
            begin
                // drop the oldest entries beyond capacity, age the rest
                for (int j = 0; j < CAPACITY; j++)
                begin
                    if (keep[j])
                    begin
                        rank_next[j] = rank_reg[j] + IW'(1);
                    end
                    else
                    begin
                        valid_next[j] = 1'b0;
                        rank_next[j]  = '0;
                    end
                end
                valid_next[slot_idx] = 1'b1;
                rank_next[slot_idx]  = '0;
                occ_next             = OW'(occ_kept + EW'(1));
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            for (int j = 0; j < CAPACITY; j++)
            begin
                rank_reg[j] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            rank_reg  <= rank_next;
        end
    end

    // key store, written on insert
    always_ff @(posedge clk)
    begin
        if (upd_en && lookup.insert)
        begin
            key_reg[slot_idx] <= key;
        end
    end

    // occupancy tracks the valid bits
    a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == OW'($countones(valid_reg)))
        else $error("occupancy count differs from valid bits");

    // occupancy stays within the array
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OW'(CAPACITY))
        else $error("occupancy beyond array size");

    // keys among valid entries are distinct
    a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match))
        else $error("key present in more than one entry");

    // an inserted entry is valid and most recent afterwards
    a_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_en && lookup.insert) |=>
            (valid_reg[$past(slot_idx)] && (rank_reg[$past(slot_idx)] == '0)))
        else $error("inserted entry not valid or not most recent");

endmodule

@@ design/lkvc_data_ram.sv @@
// value memory with one write port and one registered read port
module lkvc_data_ram #(
    parameter int unsigned CAPACITY = lkvc_pkg::CAPACITY_DEF,
    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [IW-1:0]              waddr,
    input  logic [lkvc_pkg::VAL_W-1:0] wdata,
    input  logic                       re,
    input  logic [IW-1:0]              raddr,
    output logic [lkvc_pkg::VAL_W-1:0] rdata
);

    logic [lkvc_pkg::VAL_W-1:0] mem [CAPACITY];
    logic [lkvc_pkg::VAL_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/lru_key_value_cache_core.sv @@
// top level of the lru key-value cache
//
// Fully associative key-value cache with least-recently-used replacement.
// A request (tuser: 0 get, 1 put; tdata: key, value) is taken into an input
// register; from there all entries are compared in parallel, and when the
// result register is free the recency ranks, valid bits and value memory are
// updated and the result (tuser: found; tdata: read value, or the written
// value for a put) goes to the output register. One request is taken every
// cycle while the result side keeps up. The rate is set by the parallel key
// compare and rank update across all entries. The capacity register may be
// lowered below the current occupancy; the extra oldest entries are dropped
// at the next put of a new key. Valid bits clear at reset, so no clearing
// pass is needed.
module lru_key_value_cache_core #(
    parameter int unsigned CAPACITY = lkvc_pkg::CAPACITY_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // request: tdata = key[31:0], value[63:32]; tuser = action
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [63:0]                s_tdata,
    input  logic                       s_tuser,
    // result: tdata = read_value[31:0]; tuser = found
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,
    output logic                       m_tuser,
    // capacity register
    input  logic                       cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata
);

    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [lkvc_pkg::CAP_W-1:0] cap_reg;

    logic                       req_valid_reg;
    logic                       req_valid_next;
    logic                       req_action_reg;
    logic [lkvc_pkg::KEY_W-1:0] req_key_reg;
    logic [lkvc_pkg::VAL_W-1:0] req_value_reg;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       out_found_reg;
    logic                       out_get_reg;
    logic [lkvc_pkg::VAL_W-1:0] out_wvalue_reg;

    logic                       accept;
    logic                       advance;
    lkvc_pkg::lkvc_lookup_t     lookup;
    logic [IW-1:0]              hit_idx;
    logic [IW-1:0]              slot_idx;
    logic                       ram_we;
    logic                       ram_re;
    logic [IW-1:0]              ram_waddr;
    logic [lkvc_pkg::VAL_W-1:0] ram_rdata;

    // handshake: the input stage moves on when the result register is free
    assign advance  = req_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !req_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (accept)
        begin
            req_valid_next = 1'b1;
        end
        else if (advance)
        begin
            req_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state and capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cap_reg       <= lkvc_pkg::CAP_RESET;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_action_reg <= s_tuser;
            req_key_reg    <= s_tdata[31:0];
            req_value_reg  <= s_tdata[63:32];
        end
    end

    // result flags and written value
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_found_reg  <= lookup.hit;
            out_get_reg    <= (req_action_reg == lkvc_pkg::ACT_GET);
            out_wvalue_reg <= req_value_reg;
        end
    end

    lkvc_tag_array #(
        .CAPACITY (CAPACITY)
    ) u_tags (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd_en   (advance),
        .action   (req_action_reg),
        .key      (req_key_reg),
        .cap      (cap_reg),
        .lookup   (lookup),
        .hit_idx  (hit_idx),
        .slot_idx (slot_idx)
    );

    // value memory: write on any put, read on a get hit
    assign ram_we    = advance && (req_action_reg == lkvc_pkg::ACT_PUT);
    assign ram_re    = advance && (req_action_reg == lkvc_pkg::ACT_GET) && lookup.hit;
    assign ram_waddr = lookup.hit ? hit_idx : slot_idx;

    lkvc_data_ram #(
        .CAPACITY (CAPACITY)
    ) u_data (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req_value_reg),
        .re    (ram_re),
        .raddr (hit_idx),
        .rdata (ram_rdata)
    );

    // result side
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = out_get_reg ? (out_found_reg ? ram_rdata : lkvc_pkg::READ_MISS)
                                  : out_wvalue_reg;

endmodule
